// ----- sv/clbr_pkg.sv -----
// ----------------------------------------------------------------------------
// clbr_pkg
// Shared types and constants for the character LCD buffer refresh block.
// ----------------------------------------------------------------------------
`default_nettype none

package clbr_pkg;

	// default screen geometry
	localparam int LineSlotsDef = 17;
	localparam int LineCountDef = 2;

	// fixed field widths
	localparam int PosW  = 6;
	localparam int CharW = 8;
	localparam int NibW  = 4;

	// line address commands and the blank character
	localparam logic [CharW-1:0] HdrLine1  = 8'h80;
	localparam logic [CharW-1:0] HdrLine2  = 8'hC0;
	localparam logic [CharW-1:0] BlankChar = 8'h20;

	// operation codes
	localparam logic OpTick = 1'b0;
	localparam logic OpPut  = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic apply;
	} cmd_t;

endpackage

`default_nettype wire

// ----- sv/char_lcd_buffer_refresh.sv -----
// ----------------------------------------------------------------------------
// char_lcd_buffer_refresh
// Screen buffer and 4-bit bus refresh sequencer for a character LCD.
//
// One input channel (in_valid/in_ready) carries operation, position and
// character: a tick toggles EN and, on a tick that finds EN low, drives
// the next nibble of the buffer scan (high nibble first); an on-screen put
// writes one character into the buffer and marks the screen dirty.
// One output channel (out_valid/out_ready) returns one result per input
// transaction: EN, RS, the data nibble and the dirty flag after the step.
// The controller walks capture, execute (one buffer RAM access), apply and
// output, taking one transaction at a time, and holds the result until the
// receiver takes it. The next transaction is taken the cycle after the
// result leaves.
// Reset clears the pins, scan and dirty flag at once; buffer slots read as
// their line headers or spaces until written, so no clearing pass is run.
// A stalled receiver holds the result and the block takes no new input.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_buffer_refresh #(
	parameter int LINE_SLOTS = clbr_pkg::LineSlotsDef,
	parameter int LINE_COUNT = clbr_pkg::LineCountDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        operation,
	input  wire logic [clbr_pkg::PosW-1:0]   position,
	input  wire logic [clbr_pkg::CharW-1:0]  character,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             enable_line,
	output logic                             register_select,
	output logic      [clbr_pkg::NibW-1:0]   bus_nibble,
	output logic                             screen_dirty
);

	import clbr_pkg::*;

	cmd_t cmd;

	// sequencer
	clbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// buffer and pin state
	clbr_dp #(
		.LINE_SLOTS (LINE_SLOTS),
		.LINE_COUNT (LINE_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.position        (position),
		.character       (character),
		.enable_line     (enable_line),
		.register_select (register_select),
		.bus_nibble      (bus_nibble),
		.screen_dirty    (screen_dirty)
	);

endmodule

`default_nettype wire

// ----- sv/clbr_ram.sv -----
// ----------------------------------------------------------------------------
// clbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 34
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/clbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// clbr_ctrl
// Sequencer: capture a transaction, execute, apply, then hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module clbr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output clbr_pkg::cmd_t     cmd
);

	import clbr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshakes and commands
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.apply   = (state_q == ST_APPLY);

	// checks
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state register not one-hot");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec ##1 cmd.apply ##1 out_valid)
		else $error("sequence after capture broken");

endmodule

`default_nettype wire

// ----- sv/clbr_dp.sv -----
// ----------------------------------------------------------------------------
// clbr_dp
// Datapath: screen store, scan offset, pin levels and dirty flag.
// ----------------------------------------------------------------------------
`default_nettype none

module clbr_dp #(
	parameter int LINE_SLOTS = 17,
	parameter int LINE_COUNT = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire clbr_pkg::cmd_t              cmd,
	input  wire logic                        operation,
	input  wire logic [clbr_pkg::PosW-1:0]   position,
	input  wire logic [clbr_pkg::CharW-1:0]  character,
	output logic                             enable_line,
	output logic                             register_select,
	output logic      [clbr_pkg::NibW-1:0]   bus_nibble,
	output logic                             screen_dirty
);

	import clbr_pkg::*;

	localparam int StoreSlots  = LINE_COUNT * LINE_SLOTS;
	localparam int ScreenChars = LINE_COUNT * (LINE_SLOTS - 1);
	localparam int AddrW       = $clog2(StoreSlots);
	localparam int CalcW       = ((AddrW > PosW) ? AddrW : PosW) + 2;
	localparam logic [AddrW-1:0] LastSlot  = AddrW'(StoreSlots - 1);
	localparam logic [AddrW-1:0] Line2Slot = AddrW'(LINE_SLOTS);

	// captured transaction
	logic             op_q;
	logic [PosW-1:0]  pos_q;
	logic [CharW-1:0] chr_q;

	// scan and pin state
	logic [AddrW-1:0]      offset_q;
	logic                  phase_q;
	logic                  enable_q;
	logic                  select_q;
	logic [NibW-1:0]       nibble_q;
	logic                  dirty_q;
	logic [StoreSlots-1:0] valid_q;

	logic [CalcW-1:0] pos_ext;
	logic [CalcW-1:0] put_addr_ext;
	logic [AddrW-1:0] put_addr;
	logic             put_hit;
	logic             wr_en;
	logic             rd_en;
	logic [CharW-1:0] rd_data;
	logic             at_line_start;
	logic [CharW-1:0] reset_byte;
	logic [CharW-1:0] cur_byte;

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			pos_q <= position;
			chr_q <= character;
		end
	end

	// linear position to store slot: line 1 skips one header, line 2 two
	assign pos_ext      = CalcW'(pos_q);
	assign put_hit      = (op_q == OpPut) && (pos_ext < CalcW'(ScreenChars));
	assign put_addr_ext = (pos_ext < CalcW'(LINE_SLOTS - 1)) ?
		pos_ext + CalcW'(1) : pos_ext + CalcW'(2);
	assign put_addr     = put_addr_ext[AddrW-1:0];

	assign wr_en = cmd.exec && put_hit;
	assign rd_en = cmd.exec && (op_q == OpTick);

	clbr_ram #(
		.WIDTH (CharW),
		.DEPTH (StoreSlots)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (put_addr),
		.wr_data (chr_q),
		.rd_en   (rd_en),
		.rd_addr (offset_q),
		.rd_data (rd_data)
	);

	// reset content of the slot under scan
	assign at_line_start = (offset_q == '0) ||
		((LINE_COUNT == 2) && (offset_q == Line2Slot));

	always_comb begin
		if (offset_q == '0) begin
			reset_byte = HdrLine1;
		end else if (at_line_start) begin
			reset_byte = HdrLine2;
		end else begin
			reset_byte = BlankChar;
		end
	end

	assign cur_byte = valid_q[offset_q] ? rd_data : reset_byte;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			phase_q  <= 1'b0;
			enable_q <= 1'b0;
			select_q <= 1'b0;
			nibble_q <= '0;
			dirty_q  <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (wr_en) begin
				valid_q[put_addr] <= 1'b1;
				dirty_q           <= 1'b1;
			end
			if (cmd.apply && (op_q == OpTick)) begin
				if (!enable_q) begin
					select_q <= !at_line_start;
					if (phase_q) begin
						nibble_q <= cur_byte[NibW-1:0];
						if (offset_q == LastSlot) begin
							offset_q <= '0;
							dirty_q  <= 1'b0;
						end else begin
							offset_q <= offset_q + AddrW'(1);
						end
					end else begin
						nibble_q <= cur_byte[CharW-1:NibW];
					end
					phase_q <= !phase_q;
				end
				enable_q <= !enable_q;
			end
		end
	end

	assign enable_line     = enable_q;
	assign register_select = select_q;
	assign bus_nibble      = nibble_q;
	assign screen_dirty    = dirty_q;

	// checks
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= LastSlot) else $error("scan offset past last slot");
	a_enable_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.apply |=> $stable(enable_q)) else $error("enable moved outside apply");
	a_put_sets_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> dirty_q) else $error("put did not set dirty");

endmodule

`default_nettype wire

// ----- tb/tb_char_lcd_buffer_refresh.sv -----
// ----------------------------------------------------------------------------
// tb_char_lcd_buffer_refresh
// Checks the LCD refresh block against a cycle-free model of its buffer scan.
// Directed puts and ticks come first, then long random traffic with random
// gaps and stalls on both channels. Every result transaction is compared
// field by field with the oldest predicted pin state.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_buffer_refresh;
	timeunit 1ns;
	timeprecision 1ps;

	import clbr_pkg::*;

	localparam int SlotsPerLine = LineSlotsDef;
	localparam int CharsPerLine = SlotsPerLine - 1;
	localparam int ScreenChars  = LineCountDef * CharsPerLine;
	localparam int StoreSlots   = LineCountDef * SlotsPerLine;
	localparam int QuietLimit   = 2000;
	localparam int DrainCycles  = 8;

	typedef struct packed {
		logic            en;
		logic            rs;
		logic [NibW-1:0] nib;
		logic            dirty;
	} lcd_pins_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              operation = OpTick;
	logic [PosW-1:0]   position = '0;
	logic [CharW-1:0]  character = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              enable_line;
	logic              register_select;
	logic [NibW-1:0]   bus_nibble;
	logic              screen_dirty;

	// model of the buffer and the pin sequencer
	logic [CharW-1:0]  mirror_store [StoreSlots];
	int                mirror_scan;
	logic              mirror_low;
	logic              mirror_en;
	logic              mirror_rs;
	logic [NibW-1:0]   mirror_nib;
	logic              mirror_dirty;

	lcd_pins_t         pending_pins [$];
	int                errors = 0;
	int                quiet_cycles;
	bit                sender_gaps = 1'b0;
	bit                sink_stalls = 1'b0;

	char_lcd_buffer_refresh DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.position        (position),
		.character       (character),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.enable_line     (enable_line),
		.register_select (register_select),
		.bus_nibble      (bus_nibble),
		.screen_dirty    (screen_dirty)
	);

	always #1 clk = ~clk;

	// headers in slot 0 of each line, blanks elsewhere
	function void reset_mirror();
		for (int s = 0; s < StoreSlots; s++) begin
			mirror_store[s] = BlankChar;
		end
		mirror_store[0] = HdrLine1;
		if (LineCountDef > 1) begin
			mirror_store[SlotsPerLine] = HdrLine2;
		end
		mirror_scan  = 0;
		mirror_low   = 1'b0;
		mirror_en    = 1'b0;
		mirror_rs    = 1'b0;
		mirror_nib   = '0;
		mirror_dirty = 1'b0;
	endfunction

	// advance the model by one accepted transaction, return the pin state
	function lcd_pins_t refresh_step(logic op, logic [PosW-1:0] pos, logic [CharW-1:0] chr);
		int               slot;
		logic [CharW-1:0] code;
		lcd_pins_t        pins;
		if (op == OpPut) begin
			// off-screen puts leave the buffer and the dirty flag alone
			if (int'(pos) < ScreenChars) begin
				slot = (int'(pos) / CharsPerLine) * SlotsPerLine + int'(pos) % CharsPerLine + 1;
				mirror_store[slot] = chr;
				mirror_dirty = 1'b1;
			end
		end else begin
			// a tick that finds EN low puts out the next nibble
			if (!mirror_en) begin
				mirror_rs = (mirror_scan % SlotsPerLine) != 0;
				code = mirror_store[mirror_scan];
				if (mirror_low) begin
					mirror_nib = code[3:0];
					if (mirror_scan + 1 < StoreSlots) begin
						mirror_scan = mirror_scan + 1;
					end else begin
						mirror_scan  = 0;
						mirror_dirty = 1'b0;
					end
				end else begin
					mirror_nib = code[7:4];
				end
				mirror_low = !mirror_low;
			end
			mirror_en = !mirror_en;
		end
		pins.en    = mirror_en;
		pins.rs    = mirror_rs;
		pins.nib   = mirror_nib;
		pins.dirty = mirror_dirty;
		return pins;
	endfunction

	// offer one transaction after an optional gap, predict it on acceptance
	task send_item(logic op, logic [PosW-1:0] pos, logic [CharW-1:0] chr);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		character <= chr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_pins.push_back(refresh_step(op, pos, chr));
	endtask

	// stop offering input and wait for every predicted result
	task wait_drained();
		in_valid <= 1'b0;
		while (pending_pins.size() != 0) @(posedge clk);
	endtask

	function void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	// header and the first character's high nibble right after reset
	task test_power_on_scan();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (6) send_item(OpTick, '0, '0);
	endtask

	// corner positions and codes, off-screen puts, ticks in both EN phases
	task test_put_bounds();
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		send_item(OpPut, 6'd0, 8'hFF);
		send_item(OpPut, 6'd15, 8'h0F);
		send_item(OpTick, 6'd63, 8'hFF);
		send_item(OpPut, 6'd16, 8'hF0);
		send_item(OpPut, 6'd31, 8'h00);
		send_item(OpPut, 6'd32, 8'h55);
		send_item(OpTick, '0, '0);
		send_item(OpPut, 6'd63, 8'hAA);
		send_item(OpPut, 6'd1, 8'h5A);
		send_item(OpTick, '0, '0);
	endtask

	// backlog behind a stalling receiver, then a full drain before more input
	task test_drain_pause();
		sender_gaps = 1'b0;
		sink_stalls = 1'b1;
		repeat (5) send_item(OpTick, '0, '0);
		wait_drained();
		send_item(OpPut, 6'd20, 8'h41);
		repeat (3) send_item(OpTick, '0, '0);
	endtask

	// mostly ticks so the scan wraps several times, puts mixed in
	task test_random_traffic(int count);
		logic [PosW-1:0]  pos;
		logic [CharW-1:0] chr;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				sender_gaps = $urandom_range(0, 2) != 0;
				sink_stalls = $urandom_range(0, 2) != 0;
			end
			pos = ($urandom_range(0, 9) < 7) ? PosW'($urandom_range(0, ScreenChars - 1))
			                                 : PosW'($urandom_range(0, 63));
			chr = CharW'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0) begin
				send_item(OpPut, pos, chr);
			end else begin
				send_item(OpTick, pos, chr);
			end
		end
	endtask

	// result side: random stalls, compare against the oldest prediction
	initial begin
		lcd_pins_t exp_pins;
		int        stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_stalls ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_pins.size() == 0) begin
				$error("result transaction with no prediction waiting");
				errors++;
			end else begin
				exp_pins = pending_pins.pop_front();
				check_field("enable_line", exp_pins.en, enable_line);
				check_field("register_select", exp_pins.rs, register_select);
				check_field("bus_nibble", exp_pins.nib, bus_nibble);
				check_field("screen_dirty", exp_pins.dirty, screen_dirty);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QuietLimit) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb_char_lcd_buffer_refresh NOT OK");
		$finish;
	end

	// reset, tests in turn, drain and verdict
	initial begin
		reset_mirror();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_scan();
		test_put_bounds();
		test_drain_pause();
		test_random_traffic(600);
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending_pins.size() == 0) begin
			$display("tb_char_lcd_buffer_refresh OK");
		end else begin
			$display("tb_char_lcd_buffer_refresh NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
